### design/scfbi_pkg.sv
package scfbi_pkg;

    localparam int NUM_CLASSES   = 256;
    localparam int BLOCK_ENTRIES = 8;
    localparam int NUM_BLOCKS    = 1024;

    localparam int CLS_W     = $clog2(NUM_CLASSES);
    localparam int BIDX_W    = $clog2(NUM_BLOCKS);
    localparam int BLK_W     = BIDX_W + 1;
    localparam int ENT_W     = $clog2(BLOCK_ENTRIES);
    localparam int FILL_W    = ENT_W + 1;
    localparam int EADDR_W   = BIDX_W + ENT_W;
    localparam int ENT_DEPTH = NUM_BLOCKS << ENT_W;
    localparam int CFG_W     = 9;
    localparam int LIM_W     = 16;

    localparam logic [BLK_W-1:0] NIL = BLK_W'(NUM_BLOCKS);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TAKE   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    typedef struct packed {
        logic [1:0]  op;
        logic [14:0] size_class;
        logic [31:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] taken_address;
        logic [7:0]  taken_class;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_HEAD, S_BLK, S_BLKW, S_SCAN, S_CMP, S_END, S_KWAIT,
        S_APPEND, S_AFW, S_AFR, S_NEWB, S_LINK, S_RA, S_RAW, S_REL, S_REL2, S_FIN
    } state_t;

    typedef enum logic [3:0] {
        C_NOP, C_LOAD, C_HEAD, C_BLKW, C_CMP, C_END, C_APPEND, C_AFR, C_NEWB,
        C_LINK, C_RA, C_RAW, C_REL, C_REL2, C_FIN
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic is_ins;
        logic is_rem;
        logic is_take;
        logic blk_end;
        logic n_zero;
        logic match;
        logic scan_more;
        logic append_ok;
        logic free_avail;
        logic fresh_avail;
        logic take_hit;
        logic class_more;
        logic empty_after;
        logic out_free;
    } stat_t;

endpackage

### design/scfbi_ram.sv
module scfbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/scfbi_ctrl.sv
module scfbi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  scfbi_pkg::stat_t stat,
    output scfbi_pkg::cmd_t  cmd
);
    import scfbi_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_CHECK;
            S_CHECK:  state_next = stat.reject ? S_FIN : S_HEAD;
            S_HEAD:   state_next = S_BLK;
            S_BLK:    state_next = stat.blk_end ? S_END : S_BLKW;
            S_BLKW:   state_next = (stat.is_take || stat.n_zero) ? S_BLK : S_SCAN;
            S_SCAN:   state_next = S_CMP;
            S_CMP: begin
                priority if (stat.match) begin
                    state_next = stat.is_rem ? S_RA : S_FIN;
                end else if (stat.scan_more) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_BLK;
                end
            end
            S_END: begin
                priority if (stat.is_ins) begin
                    priority if (stat.append_ok)   state_next = S_APPEND;
                    else if (stat.free_avail)      state_next = S_AFW;
                    else if (stat.fresh_avail)     state_next = S_NEWB;
                    else                           state_next = S_FIN;
                end else if (stat.is_take) begin
                    priority if (stat.take_hit)    state_next = S_RA;
                    else if (stat.class_more)      state_next = S_KWAIT;
                    else                           state_next = S_FIN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_KWAIT:  state_next = S_HEAD;
            S_APPEND: state_next = S_FIN;
            S_AFW:    state_next = S_AFR;
            S_AFR:    state_next = S_NEWB;
            S_NEWB:   state_next = S_LINK;
            S_LINK:   state_next = S_FIN;
            S_RA:     state_next = S_RAW;
            S_RAW:    state_next = stat.empty_after ? S_REL : S_FIN;
            S_REL:    state_next = S_REL2;
            S_REL2:   state_next = S_FIN;
            S_FIN:    if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = C_NOP;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = C_LOAD;
            end
            S_HEAD:   cmd = C_HEAD;
            S_BLKW:   cmd = C_BLKW;
            S_CMP:    cmd = C_CMP;
            S_END:    cmd = C_END;
            S_APPEND: cmd = C_APPEND;
            S_AFR:    cmd = C_AFR;
            S_NEWB:   cmd = C_NEWB;
            S_LINK:   cmd = C_LINK;
            S_RA:     cmd = C_RA;
            S_RAW:    cmd = C_RAW;
            S_REL:    cmd = C_REL;
            S_REL2:   cmd = C_REL2;
            S_FIN:    cmd = C_FIN;
            default:  cmd = C_NOP;
        endcase
    end

endmodule

### design/scfbi_dp.sv
module scfbi_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [scfbi_pkg::CFG_W-1:0]       cfg_wdata,
    input  scfbi_pkg::in_item_t               s_data,
    input  scfbi_pkg::cmd_t                   cmd,
    output scfbi_pkg::stat_t                  stat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output scfbi_pkg::out_item_t              m_data
);
    import scfbi_pkg::*;

    // configuration and free-pool bookkeeping
    logic [CFG_W-1:0]  cfg_reg;
    logic [BLK_W-1:0]  free_head_reg, free_head_next;
    logic [BLK_W-1:0]  fresh_reg, fresh_next;

    // request
    logic [1:0]        op_reg, op_next;
    logic [31:0]       addr_reg, addr_next;
    logic              reject_reg, reject_next;
    logic [CLS_W-1:0]  k_reg, k_next;

    // chain walk
    logic [BLK_W-1:0]  cur_reg, cur_next;
    logic [BLK_W-1:0]  prev_reg, prev_next;
    logic [BLK_W-1:0]  last_reg, last_next;
    logic [BLK_W-1:0]  lprev_reg, lprev_next;
    logic [FILL_W-1:0] lfill_reg, lfill_next;
    logic [BLK_W-1:0]  lnxt_reg, lnxt_next;
    logic [FILL_W-1:0] n_reg, n_next;
    logic [BLK_W-1:0]  nxt_reg, nxt_next;
    logic [ENT_W-1:0]  idx_reg, idx_next;
    logic [BLK_W-1:0]  steps_reg, steps_next;

    // result
    logic [1:0]        st_reg, st_next;
    logic [31:0]       taken_reg, taken_next;
    logic [7:0]        tclass_reg, tclass_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    // class head valid bits
    logic [NUM_CLASSES-1:0] hvld_reg, hvld_next;
    logic                   hvq_reg;

    // memories
    logic              head_we;
    logic [BLK_W-1:0]  head_wdata, head_q;
    logic              next_we;
    logic [BIDX_W-1:0] next_waddr;
    logic [BLK_W-1:0]  next_wdata, next_q;
    logic              fill_we;
    logic [BIDX_W-1:0] fill_waddr;
    logic [FILL_W-1:0] fill_wdata, fill_q;
    logic              ent_we;
    logic [EADDR_W-1:0] ent_waddr, ent_raddr;
    logic [31:0]       ent_wdata, ent_q;

    logic [LIM_W-1:0]  limit;
    logic [FILL_W-1:0] fill_clamp, cur_n, lfill_m1;
    logic [BLK_W-1:0]  cur_nxt;
    logic              last_nil;

    scfbi_ram #(.WIDTH(BLK_W), .DEPTH(NUM_CLASSES)) u_head (
        .aclk(aclk), .we(head_we), .waddr(k_reg), .wdata(head_wdata),
        .raddr(k_reg), .rdata(head_q)
    );

    scfbi_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(cur_reg[BIDX_W-1:0]), .rdata(next_q)
    );

    scfbi_ram #(.WIDTH(FILL_W), .DEPTH(NUM_BLOCKS)) u_fill (
        .aclk(aclk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
        .raddr(cur_reg[BIDX_W-1:0]), .rdata(fill_q)
    );

    scfbi_ram #(.WIDTH(32), .DEPTH(ENT_DEPTH)) u_ent (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_q)
    );

    assign limit = (LIM_W'(cfg_reg) < LIM_W'(NUM_CLASSES)) ? LIM_W'(cfg_reg)
                                                            : LIM_W'(NUM_CLASSES);
    assign fill_clamp = (fill_q > FILL_W'(BLOCK_ENTRIES)) ? FILL_W'(BLOCK_ENTRIES) : fill_q;
    assign cur_n      = (cmd == C_BLKW) ? fill_clamp : n_reg;
    assign cur_nxt    = (cmd == C_BLKW) ? next_q : nxt_reg;
    assign lfill_m1   = lfill_reg - FILL_W'(1);
    assign last_nil   = (last_reg == NIL);

    // entry read: the block's last entry during removal, else the scan slot
    assign ent_raddr = (cmd == C_RA) ? {last_reg[BIDX_W-1:0], lfill_m1[ENT_W-1:0]}
                                     : {cur_reg[BIDX_W-1:0], idx_reg};

    always_comb begin
        stat.reject      = reject_reg;
        stat.is_ins      = (op_reg == OP_INSERT);
        stat.is_rem      = (op_reg == OP_REMOVE);
        stat.is_take     = (op_reg == OP_TAKE);
        stat.blk_end     = (cur_reg >= NIL) || (steps_reg >= NIL);
        stat.n_zero      = (fill_clamp == '0);
        stat.match       = (ent_q == addr_reg);
        stat.scan_more   = ((FILL_W'(idx_reg) + FILL_W'(1)) < n_reg);
        stat.append_ok   = !last_nil && (lfill_reg < FILL_W'(BLOCK_ENTRIES));
        stat.free_avail  = (free_head_reg < NIL);
        stat.fresh_avail = (fresh_reg < NIL);
        stat.take_hit    = !last_nil && (lfill_reg != '0);
        stat.class_more  = ((LIM_W'(k_reg) + LIM_W'(1)) < limit);
        stat.empty_after = (lfill_reg == FILL_W'(1));
        stat.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        reject_next    = reject_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        lprev_next     = lprev_reg;
        lfill_next     = lfill_reg;
        lnxt_next      = lnxt_reg;
        n_next         = n_reg;
        nxt_next       = nxt_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        st_next        = st_reg;
        taken_next     = taken_reg;
        tclass_next    = tclass_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        hvld_next      = hvld_reg;

        head_we    = 1'b0;
        head_wdata = cur_reg;
        next_we    = 1'b0;
        next_waddr = cur_reg[BIDX_W-1:0];
        next_wdata = NIL;
        fill_we    = 1'b0;
        fill_waddr = last_reg[BIDX_W-1:0];
        fill_wdata = lfill_m1;
        ent_we     = 1'b0;
        ent_waddr  = {last_reg[BIDX_W-1:0], idx_reg};
        ent_wdata  = addr_reg;

        unique case (cmd)
            C_NOP: ;
            C_LOAD: begin
                op_next     = s_data.op;
                addr_next   = s_data.address;
                reject_next = !(LIM_W'(s_data.size_class) < limit) || (s_data.op == OP_NONE);
                k_next      = s_data.size_class[CLS_W-1:0];
                st_next     = ST_MISS;
                taken_next  = '0;
                tclass_next = '0;
            end
            C_HEAD: begin
                cur_next   = hvq_reg ? head_q : NIL;
                prev_next  = NIL;
                last_next  = NIL;
                lprev_next = NIL;
                lfill_next = '0;
                steps_next = '0;
            end
            C_BLKW, C_CMP: begin
                n_next   = cur_n;
                nxt_next = cur_nxt;
                if (cmd == C_CMP && stat.match) begin
                    // matching entry found: keep its block context for removal
                    last_next  = cur_reg;
                    lprev_next = prev_reg;
                    lfill_next = n_reg;
                    lnxt_next  = nxt_reg;
                end else if (cmd == C_CMP && stat.scan_more) begin
                    idx_next = idx_reg + ENT_W'(1);
                end else if (cmd == C_BLKW && !stat.is_take && !stat.n_zero) begin
                    idx_next = '0;
                end else begin
                    lprev_next = prev_reg;
                    last_next  = cur_reg;
                    lfill_next = cur_n;
                    lnxt_next  = cur_nxt;
                    prev_next  = cur_reg;
                    cur_next   = cur_nxt;
                    steps_next = steps_reg + BLK_W'(1);
                end
            end
            C_END: begin
                if (stat.is_ins && !stat.append_ok) begin
                    priority if (stat.free_avail) begin
                        cur_next = free_head_reg;
                    end else if (stat.fresh_avail) begin
                        cur_next   = fresh_reg;
                        fresh_next = fresh_reg + BLK_W'(1);
                    end else begin
                        st_next = ST_FULL;
                    end
                end else if (stat.is_take) begin
                    if (stat.take_hit) begin
                        idx_next = lfill_m1[ENT_W-1:0];
                    end else if (stat.class_more) begin
                        k_next = k_reg + CLS_W'(1);
                    end
                end
            end
            C_APPEND: begin
                ent_we     = 1'b1;
                ent_waddr  = {last_reg[BIDX_W-1:0], lfill_reg[ENT_W-1:0]};
                fill_we    = 1'b1;
                fill_wdata = lfill_reg + FILL_W'(1);
                st_next    = ST_DONE;
            end
            C_AFR: begin
                free_head_next = next_q;
            end
            C_NEWB: begin
                fill_we    = 1'b1;
                fill_waddr = cur_reg[BIDX_W-1:0];
                fill_wdata = FILL_W'(1);
                next_we    = 1'b1;
                next_wdata = NIL;
                ent_we     = 1'b1;
                ent_waddr  = {cur_reg[BIDX_W-1:0], ENT_W'(0)};
            end
            C_LINK: begin
                if (last_nil) begin
                    head_we          = 1'b1;
                    head_wdata       = cur_reg;
                    hvld_next[k_reg] = 1'b1;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = last_reg[BIDX_W-1:0];
                    next_wdata = cur_reg;
                end
                st_next = ST_DONE;
            end
            C_RA: ;
            C_RAW: begin
                // hole takes the block's last entry
                ent_we    = 1'b1;
                ent_waddr = {last_reg[BIDX_W-1:0], idx_reg};
                ent_wdata = ent_q;
                fill_we   = 1'b1;
                if (stat.is_take) begin
                    taken_next  = ent_q;
                    tclass_next = 8'(LIM_W'(k_reg));
                end
                st_next = ST_DONE;
            end
            C_REL: begin
                if (lprev_reg == NIL) begin
                    head_we          = 1'b1;
                    head_wdata       = lnxt_reg;
                    hvld_next[k_reg] = 1'b1;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = lprev_reg[BIDX_W-1:0];
                    next_wdata = lnxt_reg;
                end
            end
            C_REL2: begin
                next_we        = 1'b1;
                next_waddr     = last_reg[BIDX_W-1:0];
                next_wdata     = free_head_reg;
                free_head_next = last_reg;
            end
            C_FIN: begin
                if (stat.out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = st_reg;
                    m_data_next.taken_address = taken_reg;
                    m_data_next.taken_class   = tclass_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CFG_RESET;
            free_head_reg <= NIL;
            fresh_reg     <= '0;
            m_valid_reg   <= 1'b0;
            hvld_reg      <= '0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            m_valid_reg   <= m_valid_next;
            hvld_reg      <= hvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        reject_reg <= reject_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        last_reg   <= last_next;
        lprev_reg  <= lprev_next;
        lfill_reg  <= lfill_next;
        lnxt_reg   <= lnxt_next;
        n_reg      <= n_next;
        nxt_reg    <= nxt_next;
        idx_reg    <= idx_next;
        steps_reg  <= steps_next;
        st_reg     <= st_next;
        taken_reg  <= taken_next;
        tclass_reg <= tclass_next;
        m_data_reg <= m_data_next;
        hvq_reg    <= hvld_reg[k_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/size_class_free_block_index_core.sv
// Size-class free-block index. Addresses are filed by size class in chains of
// 8-entry blocks drawn from a 1024-block pool; an emptied block goes back on a
// free list that is reused before untouched pool blocks. One request (insert,
// remove, take smallest class at or above) is worked at a time and always
// returns one result item. The time taken grows with every block visited and
// every entry compared, and for a take with every empty class it passes; all
// of it is limited by the single read port of the block link, fill and entry
// memories. A new request is accepted while the previous result still waits
// on the m_ channel. No clearing pass is needed after reset: class heads
// carry valid bits, and block memories are only read where written. Write
// classes_in_use only while idle.
module size_class_free_block_index_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: classes_in_use
    input  logic                          cfg_we,
    input  logic [scfbi_pkg::CFG_W-1:0]   cfg_wdata,
    // request items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  scfbi_pkg::in_item_t           s_data,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output scfbi_pkg::out_item_t          m_data
);
    import scfbi_pkg::*;

    cmd_t  cmd;   // per-state datapath action
    stat_t stat;  // compare and bookkeeping flags back to the controller

    scfbi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scfbi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
